// File: hdl/srwq_pkg.sv
// Package for the sequenced ring index with window query.
// Holds opcodes, field widths, the walk FSM type and the cell types.
// No dependencies.
package srwq_pkg;

    localparam int SEQ_W            = 48;
    localparam int TS_W             = 48;
    localparam int IN_PL_W          = 32;
    localparam int CAPACITY_DEF     = 64;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_SNAP   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic                    v;
        logic signed [TS_W-1:0]  ts;
        logic [SEQ_W-1:0]        seq;
    } t_ent;

    typedef struct packed {
        logic ins;
        logic shift;
    } t_cell_ctl;

endpackage

// File: hdl/srwq_cell.sv
// One sorting cell of the insertion chain: holds one matching entry.
// Depends on srwq_pkg.
module srwq_cell #(
    parameter int PAYLOAD_BITS = srwq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  srwq_pkg::t_cell_ctl      i_ctl,
    input  srwq_pkg::t_ent           i_new,
    input  logic [PAYLOAD_BITS-1:0]  i_new_pl,
    input  srwq_pkg::t_ent           i_prev,
    input  logic [PAYLOAD_BITS-1:0]  i_prev_pl,
    input  logic                     i_prev_before,
    input  srwq_pkg::t_ent           i_next,
    input  logic [PAYLOAD_BITS-1:0]  i_next_pl,
    output srwq_pkg::t_ent           o_ent,
    output logic [PAYLOAD_BITS-1:0]  o_pl,
    output logic                     o_before
);
    import srwq_pkg::*;

    t_ent                    r_ent, n_ent;
    logic [PAYLOAD_BITS-1:0] r_pl, n_pl;

    assign o_before = !r_ent.v || (i_new.ts < r_ent.ts);
    assign o_ent    = r_ent;
    assign o_pl     = r_pl;

    always_comb begin
        n_ent = r_ent;
        n_pl  = r_pl;
        if (i_ctl.shift) begin
            n_ent = i_next;
            n_pl  = i_next_pl;
        end else if (i_ctl.ins && o_before) begin
            if (i_prev_before) begin
                n_ent = i_prev;
                n_pl  = i_prev_pl;
            end else begin
                n_ent = i_new;
                n_pl  = i_new_pl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.v <= 1'b0;
        end else begin
            r_ent.v <= n_ent.v;
        end
        r_ent.ts  <= n_ent.ts;
        r_ent.seq <= n_ent.seq;
        r_pl      <= n_pl;
    end

endmodule

// File: hdl/srwq_ring_mem.sv
// Slot store of the ring: timestamp and payload, one write and one
// registered read port. Depends on srwq_pkg.
module srwq_ring_mem #(
    parameter int CAPACITY     = srwq_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_BITS = srwq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [$clog2(CAPACITY)-1:0]        i_waddr,
    input  logic signed [srwq_pkg::TS_W-1:0]   i_wts,
    input  logic [PAYLOAD_BITS-1:0]            i_wpl,
    input  logic [$clog2(CAPACITY)-1:0]        i_raddr,
    output logic signed [srwq_pkg::TS_W-1:0]   o_rts,
    output logic [PAYLOAD_BITS-1:0]            o_rpl
);
    import srwq_pkg::*;

    logic signed [TS_W-1:0]  r_ts_mem [CAPACITY];
    logic [PAYLOAD_BITS-1:0] r_pl_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_ts_mem[i_waddr] <= i_wts;
            r_pl_mem[i_waddr] <= i_wpl;
        end
        o_rts <= r_ts_mem[i_raddr];
        o_rpl <= r_pl_mem[i_raddr];
    end

endmodule

// File: hdl/sequenced_ring_index_window_query.sv
// Sequenced ring index with timestamp-window query: append and clear load their
// result straight into the output register; a read passes the registered slot
// read port, then loads the result; a snapshot walks min(next_sequence, CAPACITY)
// slots through the slot store into a sorting chain, then drains the results.
// A new request enters only once the output register is free or taken.
// Synchronous active-low reset zeroes the sequence counter and empties the
// chain; slot contents are undefined until written.
module sequenced_ring_index_window_query #(
    parameter int CAPACITY     = srwq_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_BITS = srwq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // timestamp[47:0], entry_payload[79:48], seq[127:80],
    // window_start[175:128], window_end[223:176]
    input  logic [223:0] i_s_tdata,
    // op[1:0]
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // out_seq[47:0], out_timestamp[95:48], out_payload[127:96],
    // write_count[175:128]
    output logic [175:0] o_m_tdata,
    // kind[1:0], ok[2]
    output logic [2:0]   o_m_tuser,
    output logic         o_m_tlast
);
    import srwq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = AW + 1;

    t_state r_state, n_state;

    logic [SEQ_W-1:0]        r_nseq, n_nseq;
    logic                    r_ovalid, n_ovalid;
    logic [1:0]              r_okind, n_okind;
    logic                    r_ook, n_ook;
    logic [SEQ_W-1:0]        r_oseq, n_oseq;
    logic signed [TS_W-1:0]  r_ots, n_ots;
    logic [IN_PL_W-1:0]      r_opl, n_opl;
    logic [SEQ_W-1:0]        r_owc, n_owc;
    logic                    r_olast, n_olast;
    logic                    r_rd_ok, n_rd_ok;
    logic [SEQ_W-1:0]        r_rd_seq, n_rd_seq;
    logic [SEQ_W-1:0]        r_ptr, n_ptr;
    logic [CW-1:0]           r_left, n_left;
    logic                    r_sv, n_sv;
    logic [SEQ_W-1:0]        r_sseq, n_sseq;
    logic signed [TS_W-1:0]  r_wlo, n_wlo;
    logic signed [TS_W-1:0]  r_whi, n_whi;

    logic [1:0]              in_op;
    logic signed [TS_W-1:0]  in_ts, in_wlo, in_whi;
    logic [IN_PL_W-1:0]      in_pl;
    logic [SEQ_W-1:0]        in_seq;
    logic [PAYLOAD_BITS+IN_PL_W-1:0] in_pl_ext, rd_pl_ext, c0_pl_ext, st_pl_ext;
    logic [PAYLOAD_BITS-1:0] in_pl_st;

    logic                    out_free, acc, live, wrap_big, hit;
    logic [SEQ_W-1:0]        seq_diff;
    logic [AW-1:0]           raddr;
    logic signed [TS_W-1:0]  rd_ts;
    logic [PAYLOAD_BITS-1:0] rd_pl;

    t_cell_ctl               ctl;
    t_ent                    new_ent;
    t_ent                    w_ent [CAPACITY];
    logic [PAYLOAD_BITS-1:0] w_pl  [CAPACITY];
    logic                    w_bef [CAPACITY];

    assign in_op  = i_s_tuser;
    assign in_ts  = i_s_tdata[47:0];
    assign in_pl  = i_s_tdata[79:48];
    assign in_seq = i_s_tdata[127:80];
    assign in_wlo = i_s_tdata[175:128];
    assign in_whi = i_s_tdata[223:176];

    assign in_pl_ext = {{PAYLOAD_BITS{1'b0}}, in_pl};
    assign in_pl_st  = in_pl_ext[PAYLOAD_BITS-1:0];
    assign st_pl_ext = {{IN_PL_W{1'b0}}, in_pl_st};
    assign rd_pl_ext = {{IN_PL_W{1'b0}}, rd_pl};
    assign c0_pl_ext = {{IN_PL_W{1'b0}}, w_pl[0]};

    assign out_free   = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && out_free;
    assign acc        = i_s_tvalid && o_s_tready;

    assign seq_diff = r_nseq - in_seq;
    assign live     = (r_nseq > in_seq) && (seq_diff <= SEQ_W'(CAPACITY));
    assign wrap_big = r_nseq > SEQ_W'(CAPACITY);
    assign hit      = r_sv && (rd_ts >= r_wlo) && (rd_ts <= r_whi);

    always_comb begin
        case (r_state)
            S_IDLE:  raddr = in_seq[AW-1:0];
            S_READ:  raddr = r_rd_seq[AW-1:0];
            S_SCAN:  raddr = r_ptr[AW-1:0];
            default: raddr = r_ptr[AW-1:0];
        endcase
    end

    srwq_ring_mem #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (acc && (in_op == OP_APPEND)),
        .i_waddr (r_nseq[AW-1:0]),
        .i_wts   (in_ts),
        .i_wpl   (in_pl_st),
        .i_raddr (raddr),
        .o_rts   (rd_ts),
        .o_rpl   (rd_pl)
    );

    assign ctl.ins   = (r_state == S_SCAN) && hit;
    assign ctl.shift = (r_state == S_DRAIN) && out_free && w_ent[0].v;
    assign new_ent.v   = 1'b1;
    assign new_ent.ts  = rd_ts;
    assign new_ent.seq = r_sseq;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_ent                    prev_e, next_e;
        logic [PAYLOAD_BITS-1:0] prev_p, next_p;
        logic                    prev_b;
        if (g == 0) begin : g_first
            assign prev_e = '0;
            assign prev_p = '0;
            assign prev_b = 1'b0;
        end else begin : g_mid
            assign prev_e = w_ent[g-1];
            assign prev_p = w_pl[g-1];
            assign prev_b = w_bef[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign next_e = '0;
            assign next_p = '0;
        end else begin : g_inner
            assign next_e = w_ent[g+1];
            assign next_p = w_pl[g+1];
        end
        srwq_cell #(
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_new         (new_ent),
            .i_new_pl      (rd_pl),
            .i_prev        (prev_e),
            .i_prev_pl     (prev_p),
            .i_prev_before (prev_b),
            .i_next        (next_e),
            .i_next_pl     (next_p),
            .o_ent         (w_ent[g]),
            .o_pl          (w_pl[g]),
            .o_before      (w_bef[g])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc && (in_op == OP_READ)) begin
                    n_state = S_READ;
                end else if (acc && (in_op == OP_SNAP)) begin
                    n_state = S_SCAN;
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if ((r_left == '0) && !r_sv) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (out_free && (!w_ent[0].v || !w_ent[1].v)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_nseq   = r_nseq;
        n_ovalid = r_ovalid && !i_m_tready;
        n_okind  = r_okind;
        n_ook    = r_ook;
        n_oseq   = r_oseq;
        n_ots    = r_ots;
        n_opl    = r_opl;
        n_owc    = r_owc;
        n_olast  = r_olast;
        n_rd_ok  = r_rd_ok;
        n_rd_seq = r_rd_seq;
        n_ptr    = r_ptr;
        n_left   = r_left;
        n_sv     = 1'b0;
        n_sseq   = r_sseq;
        n_wlo    = r_wlo;
        n_whi    = r_whi;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (in_op)
                        OP_APPEND: begin
                            n_ovalid = 1'b1;
                            n_okind  = OP_APPEND;
                            n_ook    = 1'b1;
                            n_oseq   = r_nseq;
                            n_ots    = in_ts;
                            n_opl    = st_pl_ext[IN_PL_W-1:0];
                            n_owc    = r_nseq + 1'b1;
                            n_olast  = 1'b1;
                            n_nseq   = r_nseq + 1'b1;
                        end
                        OP_READ: begin
                            n_rd_ok  = live;
                            n_rd_seq = in_seq;
                        end
                        OP_SNAP: begin
                            n_ptr  = wrap_big ? (r_nseq - SEQ_W'(CAPACITY)) : '0;
                            n_left = wrap_big ? CW'(CAPACITY) : r_nseq[CW-1:0];
                            n_wlo  = in_wlo;
                            n_whi  = in_whi;
                        end
                        OP_CLEAR: begin
                            n_ovalid = 1'b1;
                            n_okind  = OP_CLEAR;
                            n_ook    = 1'b1;
                            n_oseq   = '0;
                            n_ots    = '0;
                            n_opl    = '0;
                            n_owc    = '0;
                            n_olast  = 1'b1;
                            n_nseq   = '0;
                        end
                        default: n_nseq = r_nseq;
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = OP_READ;
                    n_ook    = r_rd_ok;
                    n_oseq   = r_rd_seq;
                    n_ots    = r_rd_ok ? rd_ts : '0;
                    n_opl    = r_rd_ok ? rd_pl_ext[IN_PL_W-1:0] : '0;
                    n_owc    = r_nseq;
                    n_olast  = 1'b1;
                end
            end
            S_SCAN: begin
                if (r_left != '0) begin
                    n_ptr  = r_ptr + 1'b1;
                    n_left = r_left - 1'b1;
                    n_sv   = 1'b1;
                    n_sseq = r_ptr;
                end
            end
            S_DRAIN: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = OP_SNAP;
                    n_ook    = w_ent[0].v;
                    n_oseq   = w_ent[0].v ? w_ent[0].seq : '0;
                    n_ots    = w_ent[0].v ? w_ent[0].ts : '0;
                    n_opl    = w_ent[0].v ? c0_pl_ext[IN_PL_W-1:0] : '0;
                    n_owc    = r_nseq;
                    n_olast  = !w_ent[0].v || !w_ent[1].v;
                end
            end
            default: n_sv = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_nseq   <= '0;
            r_ovalid <= 1'b0;
            r_sv     <= 1'b0;
            r_left   <= '0;
        end else begin
            r_state  <= n_state;
            r_nseq   <= n_nseq;
            r_ovalid <= n_ovalid;
            r_sv     <= n_sv;
            r_left   <= n_left;
        end
        r_okind  <= n_okind;
        r_ook    <= n_ook;
        r_oseq   <= n_oseq;
        r_ots    <= n_ots;
        r_opl    <= n_opl;
        r_owc    <= n_owc;
        r_olast  <= n_olast;
        r_rd_ok  <= n_rd_ok;
        r_rd_seq <= n_rd_seq;
        r_ptr    <= n_ptr;
        r_sseq   <= n_sseq;
        r_wlo    <= n_wlo;
        r_whi    <= n_whi;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {r_owc, r_opl, r_ots, r_oseq};
    assign o_m_tuser  = {r_ook, r_okind};
    assign o_m_tlast  = r_olast;

endmodule
